// ===== rtl/mm8_pkg.sv =====
// Shared types, codes and field helpers for the 8-bit mini-MIPS execute step.
// No dependencies; used by mm8_exec, mm8_dmem and mini_mips8_execute_step.
package mm8_pkg;

  localparam int unsigned XLEN           = 8;
  localparam int unsigned IW             = 16;
  localparam int unsigned REG_COUNT      = 8;
  localparam int unsigned RIW            = $clog2(REG_COUNT);
  localparam int unsigned ADDR_SPAN      = 2 ** XLEN;
  localparam int unsigned DATA_WORDS_DEF = 256;

  typedef enum logic {
    OPN_EXEC    = 1'b0,
    OPN_PRELOAD = 1'b1
  } operation_e;

  typedef enum logic [3:0] {
    OPC_RTYPE = 4'd0,
    OPC_J     = 4'd2,
    OPC_ADDI  = 4'd4,
    OPC_BEQ   = 4'd8,
    OPC_LW    = 4'd11,
    OPC_SW    = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd2,
    FN_AND = 3'd4,
    FN_OR  = 3'd5
  } funct_e;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            pc_we;
    logic            halted;
    logic            ovf;
    logic            rw;
    logic [RIW-1:0]  ridx;
    logic [XLEN-1:0] rval;
    logic            mw;
    logic            mrd;
    logic [XLEN-1:0] maddr;
    logic [XLEN-1:0] mval;
  } exec_res_t;

  function automatic logic [RIW-1:0] f_rs(input logic [IW-1:0] w);
    return w[11:9];
  endfunction

  function automatic logic [RIW-1:0] f_rt(input logic [IW-1:0] w);
    return w[8:6];
  endfunction

endpackage

// ===== rtl/mm8_dmem.sv =====
// Data memory of the mini-MIPS: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses mm8_pkg.
module mm8_dmem #(
  parameter int unsigned DATA_WORDS = mm8_pkg::DATA_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [$clog2(DATA_WORDS)-1:0] waddr_i,
  input  logic [mm8_pkg::XLEN-1:0]      wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DATA_WORDS)-1:0] raddr_i,
  output logic [mm8_pkg::XLEN-1:0]      rdata_o
);
  import mm8_pkg::*;

  logic [XLEN-1:0]       mem_q [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_q;
  logic [XLEN-1:0]       rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mm8_exec.sv =====
// Decode and execute logic for one mini-MIPS item: ALU, branch, jump,
// effective address and preload. Purely combinational. Uses mm8_pkg.
module mm8_exec #(
  parameter int unsigned DATA_WORDS = mm8_pkg::DATA_WORDS_DEF
) (
  input  logic                     operation_i,
  input  logic [mm8_pkg::IW-1:0]   instr_i,
  input  logic [mm8_pkg::XLEN-1:0] laddr_i,
  input  logic [mm8_pkg::XLEN-1:0] lval_i,
  input  logic [mm8_pkg::XLEN-1:0] opa_i,
  input  logic [mm8_pkg::XLEN-1:0] opb_i,
  input  logic [mm8_pkg::XLEN-1:0] pc_i,
  output mm8_pkg::exec_res_t       res_o
);
  import mm8_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  typedef logic [ADDR_SPAN-1:0][AW-1:0] idx_tbl_t;

  function automatic idx_tbl_t build_idx_tbl();
    idx_tbl_t t;
    for (int i = 0; i < ADDR_SPAN; i++) begin
      t[i] = AW'(i % DATA_WORDS);
    end
    return t;
  endfunction

  localparam idx_tbl_t IDX_TBL = build_idx_tbl();

  logic [XLEN-1:0] imm8;
  logic [XLEN-1:0] pc_inc;
  logic [XLEN-1:0] add_r;
  logic [XLEN-1:0] sub_r;
  logic [XLEN-1:0] addi_r;
  logic [XLEN-1:0] ea;
  logic [XLEN-1:0] ea_idx;
  logic [XLEN-1:0] ld_idx;

  assign imm8   = {{2{instr_i[5]}}, instr_i[5:0]};
  assign pc_inc = pc_i + XLEN'(1);
  assign add_r  = opa_i + opb_i;
  assign sub_r  = opa_i - opb_i;
  assign addi_r = opa_i + imm8;
  assign ea     = opa_i + imm8;
  assign ea_idx = XLEN'(IDX_TBL[ea]);
  assign ld_idx = XLEN'(IDX_TBL[laddr_i]);

  always_comb begin
    res_o         = '0;
    res_o.next_pc = pc_i;
    if (operation_i == OPN_PRELOAD) begin
      res_o.mw    = 1'b1;
      res_o.maddr = ld_idx;
      res_o.mval  = lval_i;
    end else if (instr_i == '0) begin
      res_o.halted = 1'b1;
    end else begin
      res_o.pc_we   = 1'b1;
      res_o.next_pc = pc_inc;
      case (opcode_e'(instr_i[15:12]))
        OPC_RTYPE: begin
          res_o.ridx = instr_i[5:3];
          case (funct_e'(instr_i[2:0]))
            FN_ADD: begin
              res_o.rw   = 1'b1;
              res_o.rval = add_r;
              res_o.ovf  = ~(opa_i[XLEN-1] ^ opb_i[XLEN-1]) & (opa_i[XLEN-1] ^ add_r[XLEN-1]);
            end
            FN_SUB: begin
              res_o.rw   = 1'b1;
              res_o.rval = sub_r;
              res_o.ovf  = (opa_i[XLEN-1] ^ opb_i[XLEN-1]) & (opa_i[XLEN-1] ^ sub_r[XLEN-1]);
            end
            FN_AND: begin
              res_o.rw   = 1'b1;
              res_o.rval = opa_i & opb_i;
            end
            FN_OR: begin
              res_o.rw   = 1'b1;
              res_o.rval = opa_i | opb_i;
            end
            default: begin
              res_o.ridx = '0;
            end
          endcase
        end
        OPC_ADDI: begin
          res_o.rw   = 1'b1;
          res_o.ridx = f_rt(instr_i);
          res_o.rval = addi_r;
          res_o.ovf  = ~(opa_i[XLEN-1] ^ imm8[XLEN-1]) & (opa_i[XLEN-1] ^ addi_r[XLEN-1]);
        end
        OPC_LW: begin
          res_o.rw    = 1'b1;
          res_o.mrd   = 1'b1;
          res_o.ridx  = f_rt(instr_i);
          res_o.maddr = ea_idx;
        end
        OPC_SW: begin
          res_o.mw    = 1'b1;
          res_o.maddr = ea_idx;
          res_o.mval  = opb_i;
        end
        OPC_BEQ: begin
          if (opa_i == opb_i) begin
            res_o.next_pc = pc_inc + imm8;
          end
        end
        OPC_J: begin
          res_o.next_pc = {1'b0, instr_i[6:0]};
        end
        default: begin
          res_o.pc_we = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mini_mips8_execute_step.sv =====
// Top level of the 8-bit mini-MIPS execute step: operand capture, execute
// stage, result register, register file and PC. Uses mm8_pkg, mm8_exec, mm8_dmem.
//
// Each input transfer is one instruction (fetched at the current PC) or one
// data memory preload, and yields exactly one result. The block takes one
// item per cycle while the input is not stalled. Register operands are
// captured at the input transfer, the item executes out of the input
// register, and its result then moves into the result register. A result
// thus passes through the input register and then the result register; a
// load's data comes from the registered read port of the data memory,
// filled at the same edge as the result register. The result register
// holds a result until taken, and the input stalls only while both
// registers are full and the result is held off. Operands that an older
// item still in flight is about to write are forwarded, a load's data
// included, so back-to-back dependent items run at full rate.
// The data memory needs no clearing pass: per-entry valid bits make it read
// as zero from reset until written.
module mini_mips8_execute_step #(
  parameter int unsigned DATA_WORDS = mm8_pkg::DATA_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [mm8_pkg::IW-1:0]      instruction_i,
  input  logic [mm8_pkg::XLEN-1:0]    load_address_i,
  input  logic [mm8_pkg::XLEN-1:0]    load_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mm8_pkg::XLEN-1:0]    next_pc_o,
  output logic                        halted_o,
  output logic                        overflow_o,
  output logic                        reg_written_o,
  output logic [mm8_pkg::RIW-1:0]     reg_index_o,
  output logic [mm8_pkg::XLEN-1:0]    reg_value_o,
  output logic                        mem_written_o,
  output logic [mm8_pkg::XLEN-1:0]    mem_address_o,
  output logic [mm8_pkg::XLEN-1:0]    mem_value_o
);
  import mm8_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);

  function automatic logic [XLEN:0] pick_operand(
    input logic [RIW-1:0]  idx,
    input logic            ex_v,
    input exec_res_t       ex,
    input logic            b_v,
    input exec_res_t       bres,
    input logic [XLEN-1:0] bval,
    input logic [XLEN-1:0] rfval
  );
    logic [XLEN:0] r;
    if (ex_v && ex.rw && ex.ridx == idx) begin
      r = ex.mrd ? {1'b1, {XLEN{1'b0}}} : {1'b0, ex.rval};
    end else if (b_v && bres.rw && bres.ridx == idx) begin
      r = {1'b0, bval};
    end else begin
      r = {1'b0, rfval};
    end
    return r;
  endfunction

  logic            a_vld_q;
  operation_e      a_op_q;
  logic [IW-1:0]   a_instr_q;
  logic [XLEN-1:0] a_laddr_q;
  logic [XLEN-1:0] a_lval_q;
  logic [XLEN-1:0] a_opa_q;
  logic [XLEN-1:0] a_opb_q;
  logic            a_fwda_q;
  logic            a_fwdb_q;

  logic            b_vld_q;
  exec_res_t       b_res_q;

  logic [XLEN-1:0] pc_q;
  logic [XLEN-1:0] rf_q [REG_COUNT];

  logic            a_move;
  logic            in_fire;
  logic            out_fire;
  logic [XLEN-1:0] mem_rdata;
  logic [XLEN-1:0] b_wval;
  logic [XLEN-1:0] opa;
  logic [XLEN-1:0] opb;
  exec_res_t       ex_res;
  logic [XLEN:0]   opa_d;
  logic [XLEN:0]   opb_d;

  assign out_fire   = b_vld_q && !out_stall_i;
  assign a_move     = a_vld_q && (!b_vld_q || !out_stall_i);
  assign in_stall_o = a_vld_q && !a_move;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign b_wval = b_res_q.mrd ? mem_rdata : b_res_q.rval;
  assign opa    = a_fwda_q ? mem_rdata : a_opa_q;
  assign opb    = a_fwdb_q ? mem_rdata : a_opb_q;

  assign opa_d = pick_operand(f_rs(instruction_i), a_vld_q, ex_res, b_vld_q, b_res_q, b_wval,
                              rf_q[f_rs(instruction_i)]);
  assign opb_d = pick_operand(f_rt(instruction_i), a_vld_q, ex_res, b_vld_q, b_res_q, b_wval,
                              rf_q[f_rt(instruction_i)]);

  mm8_exec #(
    .DATA_WORDS(DATA_WORDS)
  ) u_exec (
    .operation_i(a_op_q),
    .instr_i    (a_instr_q),
    .laddr_i    (a_laddr_q),
    .lval_i     (a_lval_q),
    .opa_i      (opa),
    .opb_i      (opb),
    .pc_i       (pc_q),
    .res_o      (ex_res)
  );

  mm8_dmem #(
    .DATA_WORDS(DATA_WORDS)
  ) u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (a_move && ex_res.mw),
    .waddr_i(AW'(ex_res.maddr)),
    .wdata_i(ex_res.mval),
    .re_i   (a_move && ex_res.mrd),
    .raddr_i(AW'(ex_res.maddr)),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_fire) begin
      a_vld_q <= 1'b1;
    end else if (a_move) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_op_q    <= operation_e'(operation_i);
      a_instr_q <= instruction_i;
      a_laddr_q <= load_address_i;
      a_lval_q  <= load_value_i;
      a_opa_q   <= opa_d[XLEN-1:0];
      a_fwda_q  <= opa_d[XLEN];
      a_opb_q   <= opb_d[XLEN-1:0];
      a_fwdb_q  <= opb_d[XLEN];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (a_move) begin
      b_vld_q <= 1'b1;
    end else if (out_fire) begin
      b_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_res_q <= ex_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (a_move && ex_res.pc_we) begin
      pc_q <= ex_res.next_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else if (out_fire && b_res_q.rw) begin
      rf_q[b_res_q.ridx] <= b_wval;
    end
  end

  assign out_valid_o   = b_vld_q;
  assign next_pc_o     = b_res_q.next_pc;
  assign halted_o      = b_res_q.halted;
  assign overflow_o    = b_res_q.ovf;
  assign reg_written_o = b_res_q.rw;
  assign reg_index_o   = b_res_q.ridx;
  assign reg_value_o   = b_wval;
  assign mem_written_o = b_res_q.mw;
  assign mem_address_o = b_res_q.maddr;
  assign mem_value_o   = b_res_q.mrd ? mem_rdata : b_res_q.mval;

`ifndef SYNTHESIS
  a_fwd_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && (a_fwda_q || a_fwdb_q) |-> b_vld_q && b_res_q.mrd)
    else $error("forwarded operand without a load in the result stage");

  a_halt_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> !reg_written_o && !mem_written_o && !overflow_o)
    else $error("halt result carries side effects");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_written_o && mem_written_o))
    else $error("register and memory written by one item");

  a_preload_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move && a_op_q == OPN_PRELOAD |=> pc_q == $past(pc_q))
    else $error("preload changed the program counter");

  a_reg_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && b_res_q.rw |=> rf_q[$past(b_res_q.ridx)] == $past(b_wval))
    else $error("register file missed a committed write");
`endif

endmodule
